FILE: design/smeu_pkg.sv
// Package for the stack machine execute unit: opcodes, status codes, defaults.
// No dependencies.
`default_nettype none
package smeu_pkg;
	localparam int STACK_DEPTH_DEF = 256;
	localparam int MEM_DEPTH_DEF   = 1024;
	localparam int PC_BITS_DEF     = 16;

	typedef enum logic [4:0] {
		OP_HLT = 5'd0, OP_IN = 5'd1, OP_INCHAR = 5'd2, OP_OUT = 5'd3, OP_OUTCHAR = 5'd4,
		OP_ADD = 5'd5, OP_SUB = 5'd6, OP_MUL = 5'd7, OP_DIV = 5'd8, OP_MOD = 5'd9,
		OP_NEG = 5'd10, OP_DUP = 5'd11, OP_LOAD = 5'd12, OP_STORE = 5'd13,
		OP_CONST = 5'd14, OP_JMP = 5'd15, OP_JEQ = 5'd16, OP_JNE = 5'd17,
		OP_JLS = 5'd18, OP_JLE = 5'd19
	} op_t;

	localparam logic [2:0] ST_OK = 3'd0, ST_OVF = 3'd1, ST_UNF = 3'd2, ST_DIV0 = 3'd3,
		ST_EMPTY = 3'd4, ST_FULL = 3'd5, ST_ADDR = 3'd6;

	localparam logic [1:0] EK_NONE = 2'd0, EK_INT = 2'd1, EK_CHAR = 2'd2;

	// pops and pushes of an action
	function automatic logic [1:0] pops_of(input logic [4:0] a);
		logic [1:0] p;
		p = 2'd0;
		if (a == OP_OUT || a == OP_OUTCHAR || a == OP_NEG || a == OP_DUP || a == OP_LOAD)
			p = 2'd1;
		else if ((a >= OP_ADD && a <= OP_MOD) || a == OP_STORE || (a >= OP_JEQ && a <= OP_JLE))
			p = 2'd2;
		return p;
	endfunction

	function automatic logic [1:0] pushes_of(input logic [4:0] a);
		logic [1:0] p;
		p = 2'd0;
		if (a == OP_DUP) p = 2'd2;
		else if (a == OP_IN || a == OP_INCHAR || a == OP_CONST || (a >= OP_ADD && a <= OP_NEG)
			|| a == OP_LOAD) p = 2'd1;
		return p;
	endfunction
endpackage
`default_nettype wire

FILE: design/smeu_ram.sv
// Generic single-port-write, single-read RAM with registered read.
// No dependencies.
`default_nettype none
module smeu_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

FILE: design/smeu_div.sv
// Iterative signed 32-bit divider, one quotient bit per cycle, C truncation.
// Depends on nothing.
`default_nettype none
module smeu_div (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [31:0] dividend,
	input  wire logic [31:0] divisor,
	output logic             done,
	output logic [31:0]      quot,
	output logic [31:0]      rem
);
	logic [31:0] q_q, r_q, d_q;
	logic [5:0]  cnt_q;
	logic        busy_q, nq_q, nr_q;
	logic [32:0] trial;
	logic [31:0] rsh;

	assign rsh   = {r_q[30:0], q_q[31]};
	assign trial = {1'b0, rsh} - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd32;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q  <= dividend[31] ? 32'd0 - dividend : dividend;
			d_q  <= divisor[31] ? 32'd0 - divisor : divisor;
			r_q  <= '0;
			nq_q <= dividend[31] ^ divisor[31];
			nr_q <= dividend[31];
		end else if (busy_q) begin
			if (!trial[32]) begin
				r_q <= trial[31:0];
				q_q <= {q_q[30:0], 1'b1};
			end else begin
				r_q <= rsh;
				q_q <= {q_q[30:0], 1'b0};
			end
		end
	end

	assign quot = nq_q ? 32'd0 - q_q : q_q;
	assign rem  = nr_q ? 32'd0 - r_q : r_q;
endmodule
`default_nettype wire

FILE: design/stack_machine_execute_unit_core.sv
// Top level of the stack machine execute unit.
// Uses smeu_pkg, smeu_ram (stack and data memory) and smeu_div.
// Each item is accepted in S_IDLE, reads r (S_RD2) and l (S_MEM) from the stack,
// executes in S_EXEC, or in S_DIV for div/mod (32 divider iterations), and holds
// its result in S_OUT until out_ready. One item at a time.
// Reset: sp and pc go to zero; then a clearing pass zeroes data memory, during
// which no item is accepted.
`default_nettype none
module stack_machine_execute_unit_core #(
	parameter int STACK_DEPTH = smeu_pkg::STACK_DEPTH_DEF,
	parameter int MEM_DEPTH   = smeu_pkg::MEM_DEPTH_DEF,
	parameter int PC_BITS     = smeu_pkg::PC_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [4:0]  action,
	input  wire logic [31:0] immediate,
	input  wire logic [31:0] console_value,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [15:0]      next_pc,
	output logic [31:0]      emit_value,
	output logic [1:0]       emit_kind,
	output logic [2:0]       status,
	output logic             halted
);
	localparam int SAW = $clog2(STACK_DEPTH);
	localparam int SPW = $clog2(STACK_DEPTH + 1);
	localparam int MAW = $clog2(MEM_DEPTH);
	localparam int MCW = $clog2(MEM_DEPTH + 1);

	typedef enum logic [6:0] {
		S_CLEAR = 7'b0000001, S_IDLE = 7'b0000010, S_RD2 = 7'b0000100,
		S_MEM = 7'b0001000, S_EXEC = 7'b0010000, S_DIV = 7'b0100000,
		S_OUT = 7'b1000000
	} state_t;

	state_t state_q;
	logic [SPW-1:0] sp_q;
	logic [PC_BITS-1:0] pc_q;
	logic [MCW-1:0] clr_q;
	logic [4:0] act_q;
	logic [31:0] imm_q, con_q, r_q, l_q;
	logic [1:0] pops, pushes;

	// stack memory
	logic s_we, s_we2_q;
	logic [SAW-1:0] s_waddr, s_raddr;
	logic [31:0] s_wdata, s_rdata;
	smeu_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_stack (
		.clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
		.raddr(s_raddr), .rdata(s_rdata));

	// data memory
	logic d_we;
	logic [MAW-1:0] d_waddr, d_raddr;
	logic [31:0] d_wdata, d_rdata;
	smeu_ram #(.WIDTH(32), .DEPTH(MEM_DEPTH)) u_dmem (
		.clk(clk), .we(d_we), .waddr(d_waddr), .wdata(d_wdata),
		.raddr(d_raddr), .rdata(d_rdata));

	// divider starts in S_MEM, where l is still on the stack read port
	logic div_start, div_done;
	logic [31:0] div_q, div_r;
	smeu_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(s_rdata), .divisor(r_q),
		.done(div_done), .quot(div_q), .rem(div_r));

	assign pops   = smeu_pkg::pops_of(act_q);
	assign pushes = smeu_pkg::pushes_of(act_q);

	logic [SPW:0] sp_after;
	assign sp_after = {1'b0, sp_q} - {{(SPW-1){1'b0}}, pops} + {{(SPW-1){1'b0}}, pushes};
	logic chk_empty, chk_full;
	assign chk_empty = sp_q < {{(SPW-2){1'b0}}, pops};
	assign chk_full  = sp_after > (SPW+1)'(STACK_DEPTH);

	logic [SAW-1:0] top1, top2;
	assign top1 = SAW'(sp_q - SPW'(1));
	assign top2 = SAW'(sp_q - SPW'(2));

	// address check on r (load/store)
	logic addr_ok;
	assign addr_ok = !r_q[31] && ({1'b0, r_q} < 33'(MEM_DEPTH));

	// exec results
	logic signed [32:0] add_x, sub_x, neg_x;
	logic signed [63:0] mul_x;
	assign add_x = {l_q[31], l_q} + {r_q[31], r_q};
	assign sub_x = {l_q[31], l_q} - {r_q[31], r_q};
	assign neg_x = 33'sd0 - {r_q[31], r_q};
	assign mul_x = $signed(l_q) * $signed(r_q);

	function automatic logic [2:0] rng33(input logic [32:0] v);
		logic [2:0] s;
		s = smeu_pkg::ST_OK;
		if (v[32] != v[31]) s = v[32] ? smeu_pkg::ST_UNF : smeu_pkg::ST_OVF;
		return s;
	endfunction

	logic [PC_BITS-1:0] pc_inc, tgt;
	assign pc_inc = pc_q + PC_BITS'(1);
	assign tgt    = PC_BITS'(imm_q);

	logic [2:0] ex_st;
	logic [31:0] ex_res, ex_emit;
	logic [1:0] ex_kind;
	logic [PC_BITS-1:0] ex_pc;
	logic ex_halt;
	logic signed [31:0] ls, rs;
	assign ls = l_q;
	assign rs = r_q;

	always_comb begin
		ex_st = smeu_pkg::ST_OK; ex_res = '0; ex_emit = '0;
		ex_kind = smeu_pkg::EK_NONE; ex_pc = pc_inc; ex_halt = 1'b0;
		if (chk_empty) ex_st = smeu_pkg::ST_EMPTY;
		else if (chk_full) ex_st = smeu_pkg::ST_FULL;
		else begin
			case (act_q)
				smeu_pkg::OP_HLT: begin ex_halt = 1'b1; ex_pc = pc_q; end
				smeu_pkg::OP_IN: ex_res = con_q;
				smeu_pkg::OP_INCHAR: ex_res = {24'd0, con_q[7:0]};
				smeu_pkg::OP_OUT: begin ex_emit = r_q; ex_kind = smeu_pkg::EK_INT; end
				smeu_pkg::OP_OUTCHAR: begin
					ex_emit = {24'd0, r_q[7:0]}; ex_kind = smeu_pkg::EK_CHAR;
				end
				smeu_pkg::OP_ADD: begin ex_res = add_x[31:0]; ex_st = rng33(add_x); end
				smeu_pkg::OP_SUB: begin ex_res = sub_x[31:0]; ex_st = rng33(sub_x); end
				smeu_pkg::OP_MUL: begin
					ex_res = mul_x[31:0];
					if (mul_x > 64'sh7FFFFFFF) ex_st = smeu_pkg::ST_OVF;
					else if (mul_x < -64'sh80000000) ex_st = smeu_pkg::ST_UNF;
				end
				smeu_pkg::OP_DIV, smeu_pkg::OP_MOD: begin
					if (r_q == 32'hFFFFFFFF && l_q == 32'h80000000) ex_st = smeu_pkg::ST_OVF;
					else if (r_q == 32'd0) ex_st = smeu_pkg::ST_DIV0;
					else ex_res = (act_q == smeu_pkg::OP_DIV) ? div_q : div_r;
				end
				smeu_pkg::OP_NEG: begin ex_res = neg_x[31:0]; ex_st = rng33(neg_x); end
				smeu_pkg::OP_DUP: ex_res = r_q;
				smeu_pkg::OP_LOAD: begin
					if (!addr_ok) ex_st = smeu_pkg::ST_ADDR;
					else ex_res = d_rdata;
				end
				smeu_pkg::OP_STORE: if (!addr_ok) ex_st = smeu_pkg::ST_ADDR;
				smeu_pkg::OP_CONST: ex_res = imm_q;
				smeu_pkg::OP_JMP: ex_pc = tgt;
				smeu_pkg::OP_JEQ: if (ls == rs) ex_pc = tgt;
				smeu_pkg::OP_JNE: if (ls != rs) ex_pc = tgt;
				smeu_pkg::OP_JLS: if (ls < rs) ex_pc = tgt;
				smeu_pkg::OP_JLE: if (ls <= rs) ex_pc = tgt;
				default: ;
			endcase
		end
		if (ex_st != smeu_pkg::ST_OK) begin
			ex_pc = pc_q; ex_emit = '0; ex_kind = smeu_pkg::EK_NONE; ex_halt = 1'b0;
		end
	end

	logic is_div, div_bad;
	assign is_div  = act_q == smeu_pkg::OP_DIV || act_q == smeu_pkg::OP_MOD;
	assign div_bad = r_q == 32'd0 || (r_q == 32'hFFFFFFFF && s_rdata == 32'h80000000);
	logic commit;
	assign commit = (state_q == S_EXEC || (state_q == S_DIV && div_done)) &&
		ex_st == smeu_pkg::ST_OK;
	assign div_start = state_q == S_MEM && is_div && !chk_empty && !div_bad;

	logic [SPW-1:0] sp_base;
	assign sp_base = sp_q - SPW'(pops);

	always_comb begin
		s_raddr = top1;
		if (state_q == S_RD2) s_raddr = top2;
		s_we    = commit && pushes != 2'd0;
		s_waddr = SAW'(sp_base);
		s_wdata = ex_res;
		if (s_we2_q) begin
			s_we = 1'b1; s_waddr = SAW'(sp_q - SPW'(1)); s_wdata = r_q;
		end
		d_raddr = MAW'(r_q);
		d_we    = 1'b0; d_waddr = MAW'(r_q); d_wdata = l_q;
		if (state_q == S_CLEAR) begin
			d_we = 1'b1; d_waddr = MAW'(clr_q); d_wdata = '0;
		end else if (commit && act_q == smeu_pkg::OP_STORE) d_we = 1'b1;
	end

	assign in_ready = state_q == S_IDLE && !s_we2_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR; sp_q <= '0; pc_q <= '0; clr_q <= '0;
			out_valid <= 1'b0; s_we2_q <= 1'b0;
		end else begin
			s_we2_q <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + MCW'(1);
					if (clr_q == MCW'(MEM_DEPTH - 1)) state_q <= S_IDLE;
				end
				S_IDLE: if (in_valid && in_ready) state_q <= S_RD2;
				S_RD2: state_q <= S_MEM;
				S_MEM: state_q <= div_start ? S_DIV : S_EXEC;
				S_EXEC, S_DIV: if (state_q == S_EXEC || div_done) begin
					if (commit) begin
						sp_q <= SPW'(sp_after);
						pc_q <= ex_pc;
						if (act_q == smeu_pkg::OP_DUP) s_we2_q <= 1'b1;
					end
					out_valid <= 1'b1;
					state_q <= S_OUT;
				end
				S_OUT: if (out_ready) begin out_valid <= 1'b0; state_q <= S_IDLE; end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// payload; r read lands in S_RD2, l in S_MEM
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			act_q <= action; imm_q <= immediate; con_q <= console_value;
		end
		if (state_q == S_RD2) r_q <= s_rdata;
		if (state_q == S_MEM) l_q <= s_rdata;
		if (commit || (state_q == S_EXEC) || (state_q == S_DIV && div_done)) begin
			next_pc <= 16'(ex_pc); emit_value <= ex_emit; emit_kind <= ex_kind;
			status <= ex_st; halted <= ex_halt;
		end
	end

`ifndef NO_ASSERTIONS
	a_sp_range: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= SPW'(STACK_DEPTH)) else $error("sp out of range");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("accept while result pending");
	a_err_no_change: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && $rose(out_valid) && status != smeu_pkg::ST_OK) |-> $stable(sp_q))
		else $error("state changed on error");
	a_clear_no_accept: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CLEAR |-> !in_ready) else $error("accept during clear");
`endif
endmodule
`default_nettype wire

FILE: sim/tb_top.sv
// Testbench for stack_machine_execute_unit_core: random and directed instruction streams,
// checked against a behavioral model of stack, data memory and program counter.
// Depends on smeu_pkg and the design sources.
`timescale 1ns / 1ps
module tb_top;
	localparam int SDEPTH = smeu_pkg::STACK_DEPTH_DEF;
	localparam int MDEPTH = smeu_pkg::MEM_DEPTH_DEF;

	typedef struct packed {
		logic [4:0]  act;
		logic [31:0] imm;
		logic [31:0] con;
	} instr_t;

	typedef struct packed {
		logic [15:0] pc;
		logic [31:0] emit;
		logic [1:0]  kind;
		logic [2:0]  st;
		logic        hlt;
	} outcome_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic [4:0] action = '0;
	logic [31:0] immediate = '0;
	logic [31:0] console_value = '0;
	logic out_ready = 1'b0;
	logic in_ready, out_valid, halted;
	logic [15:0] next_pc;
	logic [31:0] emit_value;
	logic [1:0] emit_kind;
	logic [2:0] status;
	logic in_acc = 1'b0;

	stack_machine_execute_unit_core u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.action(action), .immediate(immediate), .console_value(console_value),
		.out_valid(out_valid), .out_ready(out_ready),
		.next_pc(next_pc), .emit_value(emit_value), .emit_kind(emit_kind),
		.status(status), .halted(halted)
	);

	always #1 clk = ~clk;

	// model state
	logic [31:0] m_stack [SDEPTH];
	logic [31:0] m_mem [MDEPTH];
	int unsigned m_sp;
	logic [15:0] m_pc;

	instr_t pending_instrs[$];
	outcome_t expected_outcomes[$];
	int errors = 0;
	bit stim_done = 0;
	bit hold_sender = 0;
	int gap_left = 0, burst_left = 0, stall_left = 0;

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	function automatic logic [2:0] range_st(input longint v);
		if (v > 64'sd2147483647) return smeu_pkg::ST_OVF;
		if (v < -64'sd2147483648) return smeu_pkg::ST_UNF;
		return smeu_pkg::ST_OK;
	endfunction

	function automatic outcome_t execute_instr(input instr_t it);
		outcome_t o;
		int unsigned pops, pushes;
		longint r, l, res;
		logic [15:0] pcn;
		logic [31:0] jt;
		o = '0; r = 0; l = 0; res = 0;
		pcn = m_pc + 16'd1;
		jt = it.imm;
		pops = 0; pushes = 0;
		case (it.act)
			smeu_pkg::OP_OUT, smeu_pkg::OP_OUTCHAR, smeu_pkg::OP_NEG, smeu_pkg::OP_LOAD:
				pops = 1;
			smeu_pkg::OP_DUP: begin pops = 1; pushes = 2; end
			smeu_pkg::OP_ADD, smeu_pkg::OP_SUB, smeu_pkg::OP_MUL, smeu_pkg::OP_DIV,
			smeu_pkg::OP_MOD: begin pops = 2; pushes = 1; end
			smeu_pkg::OP_STORE, smeu_pkg::OP_JEQ, smeu_pkg::OP_JNE, smeu_pkg::OP_JLS,
			smeu_pkg::OP_JLE: pops = 2;
			smeu_pkg::OP_IN, smeu_pkg::OP_INCHAR, smeu_pkg::OP_CONST: pushes = 1;
			default: ;
		endcase
		if (it.act == smeu_pkg::OP_NEG || it.act == smeu_pkg::OP_LOAD) pushes = 1;
		if (m_sp < pops) o.st = smeu_pkg::ST_EMPTY;
		else if (m_sp - pops + pushes > SDEPTH) o.st = smeu_pkg::ST_FULL;
		else begin
			if (pops >= 1) r = longint'(signed'(m_stack[m_sp - 1]));
			if (pops >= 2) l = longint'(signed'(m_stack[m_sp - 2]));
			case (it.act)
				smeu_pkg::OP_HLT: begin o.hlt = 1'b1; pcn = m_pc; end
				smeu_pkg::OP_IN: res = longint'(signed'(it.con));
				smeu_pkg::OP_INCHAR: res = it.con[7:0];
				smeu_pkg::OP_OUT: begin o.emit = r[31:0]; o.kind = smeu_pkg::EK_INT; end
				smeu_pkg::OP_OUTCHAR: begin
					o.emit = {24'd0, r[7:0]}; o.kind = smeu_pkg::EK_CHAR;
				end
				smeu_pkg::OP_ADD: begin res = l + r; o.st = range_st(res); end
				smeu_pkg::OP_SUB: begin res = l - r; o.st = range_st(res); end
				smeu_pkg::OP_MUL: begin res = l * r; o.st = range_st(res); end
				smeu_pkg::OP_DIV, smeu_pkg::OP_MOD: begin
					if (r == -1 && l == -64'sd2147483648) o.st = smeu_pkg::ST_OVF;
					else if (r == 0) o.st = smeu_pkg::ST_DIV0;
					else res = (it.act == smeu_pkg::OP_DIV) ? l / r : l % r;
				end
				smeu_pkg::OP_NEG: begin res = -r; o.st = range_st(res); end
				smeu_pkg::OP_DUP: res = r;
				smeu_pkg::OP_LOAD: begin
					if (r < 0 || r >= MDEPTH) o.st = smeu_pkg::ST_ADDR;
					else res = longint'(signed'(m_mem[r]));
				end
				smeu_pkg::OP_STORE: if (r < 0 || r >= MDEPTH) o.st = smeu_pkg::ST_ADDR;
				smeu_pkg::OP_CONST: res = longint'(signed'(it.imm));
				smeu_pkg::OP_JMP: pcn = jt[15:0];
				smeu_pkg::OP_JEQ: if (l == r) pcn = jt[15:0];
				smeu_pkg::OP_JNE: if (l != r) pcn = jt[15:0];
				smeu_pkg::OP_JLS: if (l < r) pcn = jt[15:0];
				smeu_pkg::OP_JLE: if (l <= r) pcn = jt[15:0];
				default: ;
			endcase
		end
		if (o.st != smeu_pkg::ST_OK) begin
			o.pc = m_pc; o.emit = '0; o.kind = smeu_pkg::EK_NONE; o.hlt = 1'b0;
		end else begin
			if (it.act == smeu_pkg::OP_STORE) m_mem[r] = l[31:0];
			m_sp = m_sp - pops;
			for (int k = 0; k < pushes; k++) begin
				m_stack[m_sp] = res[31:0];
				m_sp++;
			end
			m_pc = pcn;
			o.pc = pcn;
		end
		return o;
	endfunction

	// input transfer seen at the last rising edge
	always @(posedge clk) in_acc <= in_valid && in_ready;

	// sender: bursts with gaps
	always @(negedge clk) begin
		if (arst_n && !(in_valid && !in_acc)) begin
			if (gap_left > 0 || hold_sender || pending_instrs.size() == 0) begin
				if (gap_left > 0) gap_left <= gap_left - 1;
				in_valid <= 1'b0;
			end else begin
				instr_t it;
				it = pending_instrs.pop_front();
				action <= it.act; immediate <= it.imm; console_value <= it.con;
				in_valid <= 1'b1;
				expected_outcomes.push_back(execute_instr(it));
				if (burst_left > 0) burst_left <= burst_left - 1;
				else begin
					burst_left <= $urandom_range(0, 12);
					gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				end
			end
		end
	end

	// receiver: stalls on a pattern of its own
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
			if ($urandom_range(0, 9) < 2) stall_left <= $urandom_range(1, 8);
		end
	end

	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			if (expected_outcomes.size() == 0) begin
				report("unexpected result", 32'(next_pc), 32'd0);
			end else begin
				outcome_t e;
				e = expected_outcomes.pop_front();
				if (next_pc !== e.pc) report("next_pc", 32'(next_pc), 32'(e.pc));
				if (emit_value !== e.emit) report("emit_value", emit_value, e.emit);
				if (emit_kind !== e.kind) report("emit_kind", 32'(emit_kind), 32'(e.kind));
				if (status !== e.st) report("status", 32'(status), 32'(e.st));
				if (halted !== e.hlt) report("halted", 32'(halted), 32'(e.hlt));
			end
		end
	end

	task automatic add_instr(input logic [4:0] a, input logic [31:0] i, input logic [31:0] c);
		pending_instrs.push_back('{act: a, imm: i, con: c});
	endtask

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'hffff_ffff;
			3: return $urandom_range(0, 20);
			4: return $urandom_range(0, MDEPTH + 4);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [4:0] rand_action(input int unsigned depth);
		// mostly push a constant on a shallow stack, with rare invalid opcodes
		if (depth < 2 && $urandom_range(0, 3) != 0) return smeu_pkg::OP_CONST;
		if ($urandom_range(0, 30) == 0) return 5'($urandom_range(20, 31));
		return 5'($urandom_range(0, 19));
	endfunction

	initial begin
		int unsigned depth;
		logic [4:0] a;
		m_sp = 0; m_pc = '0;
		for (int k = 0; k < MDEPTH; k++) m_mem[k] = '0;
		for (int k = 0; k < SDEPTH; k++) m_stack[k] = '0;
		repeat (7) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		// directed: empty stack, extremes, every action but the conditional jumps, an invalid opcode
		add_instr(smeu_pkg::OP_ADD, 0, 0);
		add_instr(smeu_pkg::OP_OUT, 0, 0);
		add_instr(smeu_pkg::OP_HLT, 0, 0);
		add_instr(smeu_pkg::OP_CONST, 32'h7fff_ffff, 0);
		add_instr(smeu_pkg::OP_CONST, 1, 0);
		add_instr(smeu_pkg::OP_ADD, 0, 0);
		add_instr(smeu_pkg::OP_IN, 0, 32'h8000_0000);
		add_instr(smeu_pkg::OP_NEG, 0, 0);
		add_instr(smeu_pkg::OP_IN, 0, 32'hffff_ffff);
		add_instr(smeu_pkg::OP_DIV, 0, 0);
		add_instr(smeu_pkg::OP_MOD, 0, 0);
		add_instr(smeu_pkg::OP_CONST, 0, 0);
		add_instr(smeu_pkg::OP_DIV, 0, 0);
		add_instr(smeu_pkg::OP_INCHAR, 0, 32'hffff_ff9a);
		add_instr(smeu_pkg::OP_DUP, 0, 0);
		add_instr(smeu_pkg::OP_MUL, 0, 0);
		add_instr(smeu_pkg::OP_OUTCHAR, 0, 0);
		add_instr(smeu_pkg::OP_CONST, -5, 0);
		add_instr(smeu_pkg::OP_LOAD, 0, 0);
		add_instr(smeu_pkg::OP_CONST, 7, 0);
		add_instr(smeu_pkg::OP_CONST, MDEPTH - 1, 0);
		add_instr(smeu_pkg::OP_STORE, 0, 0);
		add_instr(smeu_pkg::OP_JMP, 32'hffff_ffff, 0);
		add_instr(smeu_pkg::OP_SUB, 0, 0);
		add_instr(5'd31, 0, 0);
		depth = 0;
		for (int n = 0; n < 420; n++) begin
			if (n == 250) begin
				// fill the stack to the top, then overflow it
				for (int k = 0; k < SDEPTH + 2; k++) add_instr(smeu_pkg::OP_IN, 0, $urandom);
				for (int k = 0; k < SDEPTH - 4; k++) add_instr(smeu_pkg::OP_OUT, 0, 0);
				depth = 4;
			end
			a = rand_action(depth);
			add_instr(a, rand_word(), rand_word());
			if (a == smeu_pkg::OP_CONST || a == smeu_pkg::OP_IN || a == smeu_pkg::OP_INCHAR ||
				a == smeu_pkg::OP_DUP) depth++;
			else if (a >= smeu_pkg::OP_ADD && a <= smeu_pkg::OP_MOD || a == smeu_pkg::OP_OUT ||
				a == smeu_pkg::OP_OUTCHAR) begin
				if (depth > 0) depth--;
			end else if (a == smeu_pkg::OP_STORE || a >= smeu_pkg::OP_JEQ && a <= smeu_pkg::OP_JLE)
				depth = (depth > 2) ? depth - 2 : 0;
			if (n == 100) begin
				wait (pending_instrs.size() == 0);
				hold_sender = 1;
				wait (expected_outcomes.size() == 0);
				hold_sender = 0;
			end
		end
		wait (pending_instrs.size() == 0 && !in_valid);
		wait (expected_outcomes.size() == 0);
		repeat (100) @(posedge clk);
		if (errors == 0 && expected_outcomes.size() == 0) $display("PASS");
		else $display("FAIL");
		$finish;
	end

	initial begin
		#400000;
		$display("FAIL");
		$finish;
	end
endmodule

FILE: files.f
design/smeu_pkg.sv
design/smeu_ram.sv
design/smeu_div.sv
design/stack_machine_execute_unit_core.sv
sim/tb_top.sv
